// ===== rtl/prtn_pkg.sv =====
// Shared types, constants and helpers for the progress-rate time normalizer.
// Depends on nothing; used by prtn_arith and progress_rate_time_normalizer.
package prtn_pkg;

  localparam logic [63:0] U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] U32_MAX = 32'hFFFF_FFFF;

  // Last step index of each operation in the shared unit.
  localparam logic [6:0] MUL_LAST = 7'd63;
  localparam logic [6:0] DIV_LAST = 7'd127;

  typedef struct packed {
    logic go;
    logic is_div;
  } arith_cmd_t;

  // Saturate a 128-bit value to 64 bits.
  function automatic logic [63:0] sat64(input logic [127:0] v);
    return (v[127:64] != 64'd0) ? U64_MAX : v[63:0];
  endfunction

  function automatic logic [31:0] inc_sat32(input logic [31:0] v);
    return (v == U32_MAX) ? v : v + 32'd1;
  endfunction

endpackage

// ===== rtl/prtn_arith.sv =====
// Shared iterative arithmetic unit: 64x64 shift-add multiply (64 steps)
// and 128/64 restoring divide (128 steps). Depends on prtn_pkg.
module prtn_arith import prtn_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  arith_cmd_t   cmd,
  input  logic [127:0] opa,
  input  logic [63:0]  opb,
  output logic [127:0] res,
  output logic         done
);

  logic         run;
  logic         is_div;
  logic [6:0]   cnt;
  logic [127:0] acc;
  logic [63:0]  rem;
  logic [63:0]  dvs;
  logic [63:0]  mcand;
  logic [64:0]  rr;
  logic         qb;
  logic [64:0]  psum;
  logic         last;

  always_comb begin
    rr   = {rem, acc[127]};
    qb   = (rr >= {1'b0, dvs});
    psum = {1'b0, acc[127:64]} + (acc[0] ? {1'b0, mcand} : 65'd0);
    last = is_div ? (cnt == DIV_LAST) : (cnt == MUL_LAST);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= 7'd0;
    end else begin
      done <= run && last;
      if (cmd.go) begin
        run <= 1'b1;
        cnt <= 7'd0;
      end else if (run) begin
        run <= !last;
        cnt <= cnt + 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.go) begin
      is_div <= cmd.is_div;
      rem    <= 64'd0;
      dvs    <= opb;
      mcand  <= opa[63:0];
      acc    <= cmd.is_div ? opa : {64'd0, opb};
    end else if (run) begin
      if (is_div) begin
        rem <= qb ? 64'(rr - {1'b0, dvs}) : rr[63:0];
        acc <= {acc[126:0], qb};
      end else begin
        acc <= {psum[63:0], acc[63:1]} | {psum[64], 127'd0};
      end
    end
  end

  assign res = acc;

endmodule

// ===== rtl/progress_rate_time_normalizer.sv =====
// Progress-rate time normalizer: a normalize beat runs divide, multiply, divide and
// multiply on the shared unit, plus control steps, before it strobes its result, and
// a renormalize beat runs a multiply then a divide; zero ticks or a zero reference
// rate answer straight from idle, and a rate that floors to zero or an out-of-range id
// answers after the first divide. One beat is in flight at a time; busy is high
// until its result is strobed, so the next beat can be taken at the edge that ends
// the strobe. Synchronous reset clears active flags, mean, last time and counters.
module progress_rate_time_normalizer import prtn_pkg::*; #(
  parameter int ENTITY_COUNT = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic [63:0] sim_cycles,
  input  logic [5:0]  agent_id,
  input  logic [63:0] elapsed_ticks,
  input  logic [63:0] other_mean_rate,
  output logic        done,
  output logic [63:0] result_time,
  output logic        mispredicted,
  output logic        error,
  output logic [31:0] request_total,
  output logic [31:0] mispredict_total
);

  localparam int IW = (ENTITY_COUNT > 1) ? $clog2(ENTITY_COUNT) : 1;
  localparam int CW = $clog2(ENTITY_COUNT + 1);

  // Sequencer states.
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_RN_MUL   = 4'd1;
  localparam logic [3:0] S_RN_DIV   = 4'd2;
  localparam logic [3:0] S_RATE     = 4'd3;
  localparam logic [3:0] S_MEAN_MUL = 4'd4;
  localparam logic [3:0] S_ADJ      = 4'd5;
  localparam logic [3:0] S_MEAN_DIV = 4'd6;
  localparam logic [3:0] S_PRED     = 4'd7;

  logic [3:0]  st;
  logic [IW-1:0] idx;
  logic        id_ok;
  logic [63:0] ela;
  logic [63:0] oth;
  logic [63:0] rate;
  logic [63:0] rd_rate;
  logic        rd_active;
  logic [127:0] acc_sum;
  logic [63:0] mean_rate;
  logic [63:0] last_time;
  logic [31:0] request_count;
  logic [31:0] mispredict_count;
  logic [CW-1:0] active_count;
  logic [ENTITY_COUNT-1:0] entity_active;
  logic [63:0] entity_rate [ENTITY_COUNT];

  arith_cmd_t  cmd;
  logic [127:0] opa;
  logic [63:0] opb;
  logic [127:0] ares;
  logic        adone;

  logic        in_ok;
  logic [63:0] old_rate;
  logic [CW-1:0] curr;
  logic [127:0] adj;
  logic [63:0] pred;
  logic [63:0] asat;

  prtn_arith u_arith (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .opa  (opa),
    .opb  (opb),
    .res  (ares),
    .done (adone)
  );

  // The id is checked against the entity count before it touches storage.
  assign in_ok    = (32'(agent_id) < ENTITY_COUNT);
  assign old_rate = rd_active ? rd_rate : 64'd0;
  assign curr     = rd_active ? active_count : active_count + CW'(1);
  // Mean numerator with the old rate removed, floored at zero.
  assign adj      = (acc_sum < {64'd0, old_rate}) ? 128'd0 : acc_sum - {64'd0, old_rate};
  assign pred     = (ares[127:96] != 32'd0) ? U64_MAX : ares[95:32];
  assign asat     = sat64(ares);
  assign busy     = (st != S_IDLE);

  // The rate store is read once per beat, registered, at acceptance.
  always_ff @(posedge clk) begin
    if (start && !busy && in_ok) begin
      rd_rate <= entity_rate[IW'(agent_id)];
    end
    if (st == S_MEAN_DIV && adone) begin
      entity_rate[idx] <= rate;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st               <= S_IDLE;
      cmd              <= '0;
      done             <= 1'b0;
      mean_rate        <= 64'd0;
      last_time        <= 64'd0;
      request_count    <= 32'd0;
      mispredict_count <= 32'd0;
      active_count     <= '0;
      entity_active    <= '0;
      rd_active        <= 1'b0;
    end else begin
      cmd.go <= 1'b0;
      done   <= 1'b0;
      unique case (st)
        S_IDLE: begin
          if (start && !busy) begin
            idx       <= IW'(agent_id);
            id_ok     <= in_ok;
            ela       <= elapsed_ticks;
            oth       <= other_mean_rate;
            rd_active <= in_ok ? entity_active[IW'(agent_id)] : 1'b0;
            request_total    <= request_count;
            mispredict_total <= mispredict_count;
            mispredicted     <= 1'b0;
            if (req_type) begin
              if (other_mean_rate == 64'd0) begin
                done        <= 1'b1;
                error       <= 1'b1;
                result_time <= 64'd0;
              end else begin
                cmd <= '{go: 1'b1, is_div: 1'b0};
                opa <= {64'd0, sim_cycles};
                opb <= mean_rate;
                st  <= S_RN_MUL;
              end
            end else if (elapsed_ticks == 64'd0) begin
              done        <= 1'b1;
              error       <= 1'b1;
              result_time <= last_time;
            end else begin
              cmd <= '{go: 1'b1, is_div: 1'b1};
              opa <= {32'd0, sim_cycles, 32'd0};
              opb <= elapsed_ticks;
              st  <= S_RATE;
            end
          end
        end
        S_RN_MUL: begin
          if (adone) begin
            cmd <= '{go: 1'b1, is_div: 1'b1};
            opa <= ares;
            opb <= oth;
            st  <= S_RN_DIV;
          end
        end
        S_RN_DIV: begin
          if (adone) begin
            done        <= 1'b1;
            error       <= 1'b0;
            result_time <= asat;
            st          <= S_IDLE;
          end
        end
        S_RATE: begin
          if (adone) begin
            if (asat == 64'd0 || !id_ok) begin
              done        <= 1'b1;
              error       <= 1'b1;
              result_time <= last_time;
              st          <= S_IDLE;
            end else begin
              rate <= asat;
              cmd  <= '{go: 1'b1, is_div: 1'b0};
              opa  <= {64'd0, mean_rate};
              opb  <= 64'(active_count);
              st   <= S_MEAN_MUL;
            end
          end
        end
        S_MEAN_MUL: begin
          if (adone) begin
            acc_sum <= ares + {64'd0, rate};
            st      <= S_ADJ;
          end
        end
        S_ADJ: begin
          cmd <= '{go: 1'b1, is_div: 1'b1};
          opa <= adj;
          opb <= 64'(curr);
          st  <= S_MEAN_DIV;
        end
        S_MEAN_DIV: begin
          if (adone) begin
            mean_rate          <= asat;
            entity_active[idx] <= 1'b1;
            active_count       <= curr;
            cmd <= '{go: 1'b1, is_div: 1'b0};
            opa <= {64'd0, asat};
            opb <= ela;
            st  <= S_PRED;
          end
        end
        S_PRED: begin
          if (adone) begin
            done          <= 1'b1;
            error         <= 1'b0;
            request_count <= inc_sat32(request_count);
            request_total <= inc_sat32(request_count);
            if (pred < last_time) begin
              mispredicted     <= 1'b1;
              mispredict_count <= inc_sat32(mispredict_count);
              mispredict_total <= inc_sat32(mispredict_count);
              result_time      <= last_time;
            end else begin
              result_time <= pred;
              last_time   <= pred;
            end
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  // Results are strobed only while the sequencer is idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobed while the sequencer is running");
  // A clamped prediction is never also an error.
  a_mis_err: assert property (@(posedge clk) disable iff (rst)
    done && mispredicted |-> !error)
    else $error("misprediction flagged on an error result");
  // Every misprediction is also a counted request.
  a_cnt_order: assert property (@(posedge clk) disable iff (rst)
    mispredict_count <= request_count)
    else $error("mispredict count exceeds request count");
  // An accepted long beat keeps the block busy.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !req_type && elapsed_ticks != 64'd0 |=> busy)
    else $error("block not busy after accepting a normalize beat");

endmodule
